>>> hdl/mdbe_pkg.sv
// ----------------------------------------------------------------------------
// mdbe_pkg
// shared widths, register indexes and reset values of the debounce unit
// ----------------------------------------------------------------------------
package mdbe_pkg;

    localparam int PIN_W        = 8;
    localparam int CNT_W        = 10;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 10;
    localparam int DEF_CHANNELS = 8;

    localparam logic [CNT_W-1:0] DEF_DEBOUNCE_TICKS = CNT_W'(50);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 4'd0,
        CFG_INVERT_MASK    = 4'd1,
        CFG_RISING_MASK    = 4'd2,
        CFG_FALLING_MASK   = 4'd3
    } cfg_reg_t;

endpackage

>>> hdl/multi_input_debounce_edge_events_unit.sv
// ----------------------------------------------------------------------------
// multi_input_debounce_edge_events_unit
// multi-channel timed debounce with rising/falling events and a wake report
// ----------------------------------------------------------------------------
// Each accepted word on the input channel is one time tick carrying the raw
// pin levels. The first tick after reset loads the stable levels from the
// pins (xor invert_mask) and raises no events. Later, a pin that changes
// restarts its countdown at debounce_ticks (zero acts as one); when a
// countdown runs out the pin is sampled, the stable level updated and a
// rising or falling flag raised. wake reports the lowest channel whose flag
// meets rising_mask or falling_mask, with its new level. Throughput is one
// word per clock unless stalled: all channel counters update in parallel in
// the cycle the tick is accepted, and the result word is valid in a single
// output register in the next cycle. in_ready stays high while that register
// is empty or being taken in the same cycle; while a result waits unaccepted
// the input is held off, and at most one result word is held inside the
// block. Configuration writes are always accepted (cfg_ready is tied high);
// indexes beyond the four registers are ignored. Channels at index CHANNELS
// or above (and at eight or above) are ignored and read as zero.
// ----------------------------------------------------------------------------
module multi_input_debounce_edge_events_unit
    import mdbe_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // tick input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIN_W-1:0]      pin_levels,

    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIN_W-1:0]      stable_levels,
    output logic [PIN_W-1:0]      rising_flags,
    output logic [PIN_W-1:0]      falling_flags,
    output logic                  wake,
    output logic [IDX_W-1:0]      wake_index,
    output logic                  wake_value
);

    // channels that actually exist, limited by the field width
    localparam int ACTIVE = (CHANNELS > PIN_W) ? PIN_W : CHANNELS;
    localparam logic [PIN_W-1:0] CH_MASK = PIN_W'((1 << ACTIVE) - 1);

    // configuration registers
    logic [CNT_W-1:0] debounce_ticks_reg;
    logic [PIN_W-1:0] invert_mask_reg;
    logic [PIN_W-1:0] rising_mask_reg;
    logic [PIN_W-1:0] falling_mask_reg;

    // debounce state
    logic [PIN_W-1:0] previous_raw_reg, previous_raw_next;
    logic [PIN_W-1:0] stable_value_reg, stable_value_next;
    logic             primed_reg;
    logic [CNT_W-1:0] settle_count_reg  [ACTIVE];
    logic [CNT_W-1:0] settle_count_next [ACTIVE];

    // result register
    logic             out_valid_reg;
    logic [PIN_W-1:0] stable_levels_reg;
    logic [PIN_W-1:0] rising_flags_reg,  rising_next;
    logic [PIN_W-1:0] falling_flags_reg, falling_next;
    logic             wake_reg,          wake_next;
    logic [IDX_W-1:0] wake_index_reg,    wake_index_next;
    logic             wake_value_reg,    wake_value_next;

    logic             in_fire;
    logic [PIN_W-1:0] raw;
    logic [PIN_W-1:0] sampled;
    logic [PIN_W-1:0] changed;
    logic [PIN_W-1:0] match;
    logic [CNT_W-1:0] reload;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEF_DEBOUNCE_TICKS;
            invert_mask_reg    <= '0;
            rising_mask_reg    <= '0;
            falling_mask_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[CNT_W-1:0];
                CFG_INVERT_MASK:    invert_mask_reg    <= cfg_data[PIN_W-1:0];
                CFG_RISING_MASK:    rising_mask_reg    <= cfg_data[PIN_W-1:0];
                CFG_FALLING_MASK:   falling_mask_reg   <= cfg_data[PIN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign raw     = pin_levels & CH_MASK;
    assign sampled = (raw ^ invert_mask_reg) & CH_MASK;
    assign changed = raw ^ previous_raw_reg;
    assign reload  = (debounce_ticks_reg == '0) ? CNT_W'(1) : debounce_ticks_reg;

    // per-channel countdown and sampling
    always_comb
    begin
        rising_next       = '0;
        falling_next      = '0;
        stable_value_next = stable_value_reg;
        previous_raw_next = raw;
        for (int i = 0; i < ACTIVE; i++)
        begin
            settle_count_next[i] = settle_count_reg[i];
        end
        if (!primed_reg)
        begin
            // priming tick: load levels, no events
            stable_value_next = sampled;
        end
        else
        begin
            for (int i = 0; i < ACTIVE; i++)
            begin
                if (changed[i])
                begin
                    settle_count_next[i] = reload;
                end
                else if (settle_count_reg[i] != '0)
                begin
                    settle_count_next[i] = settle_count_reg[i] - CNT_W'(1);
                    if (settle_count_reg[i] == CNT_W'(1))
                    begin
                        rising_next[i]       = sampled[i] && !stable_value_reg[i];
                        falling_next[i]      = !sampled[i] && stable_value_reg[i];
                        stable_value_next[i] = sampled[i];
                    end
                end
            end
        end
    end

    // lowest matching channel
    assign match = ((rising_next & rising_mask_reg) | (falling_next & falling_mask_reg))
                   & CH_MASK;

    always_comb
    begin
        wake_next       = 1'b0;
        wake_index_next = '0;
        wake_value_next = 1'b0;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                wake_next       = 1'b1;
                wake_index_next = IDX_W'(i);
                wake_value_next = stable_value_next[i];
            end
        end
    end

    // state update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            previous_raw_reg <= '0;
            stable_value_reg <= '0;
            for (int i = 0; i < ACTIVE; i++)
            begin
                settle_count_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            primed_reg       <= 1'b1;
            previous_raw_reg <= previous_raw_next;
            stable_value_reg <= stable_value_next;
            for (int i = 0; i < ACTIVE; i++)
            begin
                settle_count_reg[i] <= settle_count_next[i];
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stable_levels_reg <= stable_value_next;
            rising_flags_reg  <= rising_next;
            falling_flags_reg <= falling_next;
            wake_reg          <= wake_next;
            wake_index_reg    <= wake_index_next;
            wake_value_reg    <= wake_value_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stable_levels = stable_levels_reg;
    assign rising_flags  = rising_flags_reg;
    assign falling_flags = falling_flags_reg;
    assign wake          = wake_reg;
    assign wake_index    = wake_index_reg;
    assign wake_value    = wake_value_reg;

endmodule
